// ===== rtl/core/fsa_pkg.sv =====
// ----------------------------------------------------------------------------
// fsa_pkg
// Shared types, opcodes and constants for the stack alu block.
// ----------------------------------------------------------------------------
package fsa_pkg;

  localparam int DATA_DEPTH   = 64;
  localparam int RETURN_DEPTH = 64;
  localparam int DA_W  = $clog2(DATA_DEPTH);
  localparam int RA_W  = $clog2(RETURN_DEPTH);
  localparam int CNT_W = 7;
  localparam int DIV_CNT_W = 7;

  typedef enum logic [5:0] {
    OP_LIT = 6'd0, OP_DUP = 6'd1, OP_DROP = 6'd2, OP_OVER = 6'd3, OP_SWAP = 6'd4,
    OP_ROT = 6'd5, OP_PICK = 6'd6, OP_2DUP = 6'd7, OP_2DROP = 6'd8, OP_2OVER = 6'd9,
    OP_2SWAP = 6'd10, OP_ADD = 6'd11, OP_MUL = 6'd12, OP_SUB = 6'd13, OP_DIV = 6'd14,
    OP_MOD = 6'd15, OP_MULDIV = 6'd16, OP_DIVMOD = 6'd17, OP_MULDIVMOD = 6'd18,
    OP_AND = 6'd19, OP_OR = 6'd20, OP_XOR = 6'd21, OP_ABS = 6'd22, OP_NEG = 6'd23,
    OP_MAX = 6'd24, OP_MIN = 6'd25, OP_SHL = 6'd26, OP_SHR = 6'd27, OP_INC = 6'd28,
    OP_DEC = 6'd29, OP_ZEQ = 6'd30, OP_ZLT = 6'd31, OP_ZGT = 6'd32, OP_EQ = 6'd33,
    OP_GT = 6'd34, OP_LT = 6'd35, OP_NE = 6'd36, OP_GE = 6'd37, OP_LE = 6'd38,
    OP_TOR = 6'd39, OP_FROMR = 6'd40, OP_RFETCH = 6'd41
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_DATA_UNDER = 3'd1, ST_DATA_OVER = 3'd2, ST_DIV_ZERO = 3'd3,
    ST_RET_UNDER = 3'd4, ST_RET_OVER = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_EXEC, S_MUL, S_DIVS, S_DIVW, S_WR, S_RDS, S_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic wide;
  } div_req_t;

  localparam logic [31:0] TRUE32 = 32'hFFFF_FFFF;

  // entries needed below the top register
  function automatic logic [1:0] need_of(input logic [5:0] k);
    logic [1:0] n;
    n = 2'd0;
    case (k) inside
      OP_DROP, OP_OVER, OP_SWAP, OP_2DUP, OP_ADD, OP_MUL, OP_SUB, OP_DIV, OP_MOD,
      OP_DIVMOD, OP_AND, OP_OR, OP_XOR, OP_MAX, OP_MIN, OP_EQ, OP_GT, OP_LT,
      OP_NE, OP_GE, OP_LE, OP_TOR: n = 2'd1;
      OP_ROT, OP_2DROP, OP_MULDIV, OP_MULDIVMOD: n = 2'd2;
      OP_2OVER, OP_2SWAP: n = 2'd3;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

  // entries added to the data store
  function automatic logic [1:0] grow_of(input logic [5:0] k);
    logic [1:0] g;
    g = 2'd0;
    case (k) inside
      OP_LIT, OP_DUP, OP_OVER, OP_FROMR, OP_RFETCH: g = 2'd1;
      OP_2DUP, OP_2OVER: g = 2'd2;
      default: g = 2'd0;
    endcase
    return g;
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] a);
    return a[31] ? (32'd0 - a) : a;
  endfunction

endpackage

// ===== rtl/core/fsa_alu.sv =====
// ----------------------------------------------------------------------------
// fsa_alu
// Combinational logic, add, shift and compare unit for ops other than mul/div.
// ----------------------------------------------------------------------------
module fsa_alu (
  input  logic [5:0]  kind,
  input  logic [31:0] n,
  input  logic [31:0] t,
  output logic [31:0] res
);

  logic lt_nt;
  logic lt_tn;

  assign lt_nt = $signed(n) < $signed(t);
  assign lt_tn = $signed(t) < $signed(n);

  // second op top, unary ops on top
  always_comb begin
    res = t;
    unique case (fsa_pkg::op_t'(kind))
      fsa_pkg::OP_ADD: res = n + t;
      fsa_pkg::OP_SUB: res = n - t;
      fsa_pkg::OP_AND: res = n & t;
      fsa_pkg::OP_OR:  res = n | t;
      fsa_pkg::OP_XOR: res = n ^ t;
      fsa_pkg::OP_ABS: res = fsa_pkg::mag32(t);
      fsa_pkg::OP_NEG: res = 32'd0 - t;
      fsa_pkg::OP_MAX: res = lt_nt ? t : n;
      fsa_pkg::OP_MIN: res = lt_tn ? t : n;
      fsa_pkg::OP_SHL: res = {t[30:0], 1'b0};
      fsa_pkg::OP_SHR: res = {t[31], t[31:1]};
      fsa_pkg::OP_INC: res = t + 32'd1;
      fsa_pkg::OP_DEC: res = t - 32'd1;
      fsa_pkg::OP_ZEQ: res = (t == 32'd0) ? fsa_pkg::TRUE32 : 32'd0;
      fsa_pkg::OP_ZLT: res = t[31] ? fsa_pkg::TRUE32 : 32'd0;
      fsa_pkg::OP_ZGT: res = ($signed(t) > 32'sd0) ? fsa_pkg::TRUE32 : 32'd0;
      fsa_pkg::OP_EQ:  res = (n == t) ? fsa_pkg::TRUE32 : 32'd0;
      fsa_pkg::OP_GT:  res = lt_tn ? fsa_pkg::TRUE32 : 32'd0;
      fsa_pkg::OP_LT:  res = lt_nt ? fsa_pkg::TRUE32 : 32'd0;
      fsa_pkg::OP_NE:  res = (n != t) ? fsa_pkg::TRUE32 : 32'd0;
      fsa_pkg::OP_GE:  res = !lt_nt ? fsa_pkg::TRUE32 : 32'd0;
      fsa_pkg::OP_LE:  res = !lt_tn ? fsa_pkg::TRUE32 : 32'd0;
      default: res = t;
    endcase
  end

endmodule

// ===== rtl/core/fsa_div.sv =====
// ----------------------------------------------------------------------------
// fsa_div
// Restoring unsigned divider, one quotient bit per cycle: 32 steps for a
// 32-bit dividend, 64 steps for a 64-bit one.
// ----------------------------------------------------------------------------
module fsa_div (
  input  logic              clk,
  input  logic              rst_n,
  input  fsa_pkg::div_req_t req,
  input  logic [63:0]       num,
  input  logic [31:0]       den,
  output logic              done,
  output logic [31:0]       quo,
  output logic [31:0]       rem
);

  logic                          busy_r;
  logic                          done_r;
  logic [fsa_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [63:0]                   num_r;
  logic [31:0]                   den_r;
  logic [31:0]                   rem_r;
  logic [31:0]                   quo_r;
  logic [32:0]                   trial;
  logic [32:0]                   diff;
  logic                          fits;

  // one trial subtract per step
  assign trial = {rem_r, num_r[63]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = !diff[32];

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.wide ? fsa_pkg::DIV_CNT_W'(64) : fsa_pkg::DIV_CNT_W'(32);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == fsa_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.wide ? num : {num[31:0], 32'd0};
      den_r <= den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[62:0], 1'b0};
      rem_r <= fits ? diff[31:0] : trial[31:0];
      quo_r <= {quo_r[30:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/core/forth_stack_alu.sv =====
// ----------------------------------------------------------------------------
// forth_stack_alu
// Forth data-stack primitives on a cached top register, a data stack memory
// and a return stack memory, run by a small sequencer around shared units.
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  input     in_kind, in_literal                     start & !busy
//  result    out_top_value .. out_status             out_strobe, one cycle
//
//  most operations pass these steps from the accepting edge to the end of
//  the result beat: five read slots, execute, a write phase of one slot per
//  store write (up to three) plus a closing slot, a read-back of the second
//  entry and the result beat; the next beat is taken back in idle
//  / mod /mod add a wait on the bit-serial divider; the multiply-divide ops
//  add a multiply, then 64 divider steps; the divider sets the worst case
//  reset clears the counts and sets the top register to -1
//  busy stays high from the accepted beat until the result beat is shown;
//  the receiver cannot stall, so results are never held back
// ----------------------------------------------------------------------------
module forth_stack_alu (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [5:0]  in_kind,
  input  logic signed [31:0] in_literal,
  output logic        out_strobe,
  output logic signed [31:0] out_top_value,
  output logic signed [31:0] out_second_value,
  output logic [6:0]  out_data_depth,
  output logic [6:0]  out_return_depth,
  output logic [2:0]  out_status
);

  localparam int DA_W  = fsa_pkg::DA_W;
  localparam int RA_W  = fsa_pkg::RA_W;
  localparam int CNT_W = fsa_pkg::CNT_W;

  fsa_pkg::state_t  state_r, state_nxt;
  fsa_pkg::status_t st_r, st_nxt, chk;
  logic [5:0]       kind_r;
  logic [31:0]      lit_r;
  logic [31:0]      t_r, t_nxt;
  logic [CNT_W-1:0] c_r, c_nxt;
  logic [CNT_W-1:0] rc_r, rc_nxt;
  logic [2:0]       idx_r, idx_nxt;
  logic [31:0]      n1_r, n2_r, n3_r, pk_r, rv_r;
  logic [63:0]      prod_r;
  logic [DA_W-1:0]  wa_r [3];
  logic [DA_W-1:0]  wa_nxt [3];
  logic [31:0]      wd_r [3];
  logic [31:0]      wd_nxt [3];
  logic [1:0]       wn_r, wn_nxt, wi_r, wi_nxt;
  logic             rw_r, rw_nxt;
  logic [RA_W-1:0]  rwa_r, rwa_nxt;
  logic [31:0]      rwd_r, rwd_nxt;

  logic [31:0]      dmem [fsa_pkg::DATA_DEPTH];
  logic [31:0]      rmem [fsa_pkg::RETURN_DEPTH];
  logic [31:0]      drd_r, rrd_r;
  logic [DA_W-1:0]  dra, dwa;
  logic [31:0]      dwd;
  logic             dwe;

  logic [31:0]      alu_res;
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      prod;
  fsa_pkg::div_req_t div_req;
  logic [63:0]      div_num;
  logic             div_done;
  logic [31:0]      div_q, div_r, q_fix, r_fix;
  logic             nneg, dneg;

  logic [DA_W-1:0]  a0, ap1, am1, am2, am3;
  logic [CNT_W:0]   c_grow;

  assign a0  = c_r[DA_W-1:0];
  assign ap1 = a0 + 1'b1;
  assign am1 = a0 - 1'b1;
  assign am2 = a0 - 2'd2;
  assign am3 = a0 - 2'd3;

  // fault checks in priority order
  assign c_grow = {1'b0, c_r} + (CNT_W + 1)'(fsa_pkg::grow_of(kind_r));
  always_comb begin
    chk = fsa_pkg::ST_OK;
    if (kind_r <= 6'(fsa_pkg::OP_RFETCH)) begin
      if ((kind_r == 6'(fsa_pkg::OP_FROMR) || kind_r == 6'(fsa_pkg::OP_RFETCH))
          && rc_r == '0)
        chk = fsa_pkg::ST_RET_UNDER;
      else if (c_r < CNT_W'(fsa_pkg::need_of(kind_r)))
        chk = fsa_pkg::ST_DATA_UNDER;
      else if (kind_r == 6'(fsa_pkg::OP_PICK) && t_r >= 32'(c_r))
        chk = fsa_pkg::ST_DATA_UNDER;
      else if (c_grow > (CNT_W + 1)'(fsa_pkg::DATA_DEPTH))
        chk = fsa_pkg::ST_DATA_OVER;
      else if (kind_r == 6'(fsa_pkg::OP_TOR) && rc_r >= CNT_W'(fsa_pkg::RETURN_DEPTH))
        chk = fsa_pkg::ST_RET_OVER;
      else if (kind_r >= 6'(fsa_pkg::OP_DIV) && kind_r <= 6'(fsa_pkg::OP_MULDIVMOD)
               && t_r == 32'd0)
        chk = fsa_pkg::ST_DIV_ZERO;
    end
  end

  // shared units
  fsa_alu u_alu (.kind(kind_r), .n(n1_r), .t(t_r), .res(alu_res));

  assign mul_a = (state_r == fsa_pkg::S_MUL) ? fsa_pkg::mag32(n1_r) : n1_r;
  assign mul_b = (state_r == fsa_pkg::S_MUL) ? fsa_pkg::mag32(n2_r) : t_r;
  assign prod  = mul_a * mul_b;

  assign div_req.start = (state_r == fsa_pkg::S_DIVS) ||
                         (state_r == fsa_pkg::S_EXEC && chk == fsa_pkg::ST_OK &&
                          (kind_r == 6'(fsa_pkg::OP_DIV) || kind_r == 6'(fsa_pkg::OP_MOD) ||
                           kind_r == 6'(fsa_pkg::OP_DIVMOD)));
  assign div_req.wide  = (state_r == fsa_pkg::S_DIVS);
  assign div_num = div_req.wide ? prod_r : {32'd0, fsa_pkg::mag32(n1_r)};

  fsa_div u_div (
    .clk(clk), .rst_n(rst_n), .req(div_req), .num(div_num),
    .den(fsa_pkg::mag32(t_r)), .done(div_done), .quo(div_q), .rem(div_r)
  );

  // signs of quotient and remainder
  assign nneg  = (kind_r == 6'(fsa_pkg::OP_MULDIV) || kind_r == 6'(fsa_pkg::OP_MULDIVMOD))
                 ? (n1_r[31] ^ n2_r[31]) : n1_r[31];
  assign dneg  = t_r[31];
  assign q_fix = (nneg ^ dneg) ? (32'd0 - div_q) : div_q;
  assign r_fix = nneg ? (32'd0 - div_r) : div_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fsa_pkg::S_IDLE: if (start) state_nxt = fsa_pkg::S_RD;
      fsa_pkg::S_RD:   if (idx_r == 3'd4) state_nxt = fsa_pkg::S_EXEC;
      fsa_pkg::S_EXEC: begin
        if (chk != fsa_pkg::ST_OK)
          state_nxt = fsa_pkg::S_RDS;
        else if (div_req.start)
          state_nxt = fsa_pkg::S_DIVW;
        else if (kind_r == 6'(fsa_pkg::OP_MULDIV) || kind_r == 6'(fsa_pkg::OP_MULDIVMOD))
          state_nxt = fsa_pkg::S_MUL;
        else
          state_nxt = fsa_pkg::S_WR;
      end
      fsa_pkg::S_MUL:  state_nxt = fsa_pkg::S_DIVS;
      fsa_pkg::S_DIVS: state_nxt = fsa_pkg::S_DIVW;
      fsa_pkg::S_DIVW: if (div_done) state_nxt = fsa_pkg::S_WR;
      fsa_pkg::S_WR:   if (wi_r == wn_r) state_nxt = fsa_pkg::S_RDS;
      fsa_pkg::S_RDS:  state_nxt = fsa_pkg::S_OUT;
      fsa_pkg::S_OUT:  state_nxt = fsa_pkg::S_IDLE;
      default:         state_nxt = fsa_pkg::S_IDLE;
    endcase
  end

  // datapath and write list
  always_comb begin
    t_nxt   = t_r;
    c_nxt   = c_r;
    rc_nxt  = rc_r;
    st_nxt  = st_r;
    idx_nxt = idx_r;
    wa_nxt  = wa_r;
    wd_nxt  = wd_r;
    wn_nxt  = wn_r;
    wi_nxt  = wi_r;
    rw_nxt  = rw_r;
    rwa_nxt = rwa_r;
    rwd_nxt = rwd_r;
    dra     = am1;
    dwe     = 1'b0;
    dwa     = wa_r[wi_r];
    dwd     = wd_r[wi_r];
    unique case (state_r)
      fsa_pkg::S_IDLE: begin
        idx_nxt = '0;
        wn_nxt  = '0;
        wi_nxt  = '0;
        rw_nxt  = 1'b0;
      end
      fsa_pkg::S_RD: begin
        idx_nxt = idx_r + 1'b1;
        case (idx_r)
          3'd0: dra = am1;
          3'd1: dra = am2;
          3'd2: dra = am3;
          default: dra = am1 - t_r[DA_W-1:0];
        endcase
      end
      fsa_pkg::S_EXEC: begin
        st_nxt = chk;
        if (chk == fsa_pkg::ST_OK) begin
          unique case (kind_r) inside
            6'(fsa_pkg::OP_LIT): begin
              wa_nxt[0] = a0; wd_nxt[0] = t_r; wn_nxt = 2'd1;
              c_nxt = c_r + 1'b1; t_nxt = lit_r;
            end
            6'(fsa_pkg::OP_DUP): begin
              wa_nxt[0] = a0; wd_nxt[0] = t_r; wn_nxt = 2'd1; c_nxt = c_r + 1'b1;
            end
            6'(fsa_pkg::OP_DROP): begin
              t_nxt = n1_r; c_nxt = c_r - 1'b1;
            end
            6'(fsa_pkg::OP_OVER): begin
              wa_nxt[0] = a0; wd_nxt[0] = t_r; wn_nxt = 2'd1;
              c_nxt = c_r + 1'b1; t_nxt = n1_r;
            end
            6'(fsa_pkg::OP_SWAP): begin
              wa_nxt[0] = am1; wd_nxt[0] = t_r; wn_nxt = 2'd1; t_nxt = n1_r;
            end
            6'(fsa_pkg::OP_ROT): begin
              wa_nxt[0] = am2; wd_nxt[0] = n1_r;
              wa_nxt[1] = am1; wd_nxt[1] = t_r; wn_nxt = 2'd2; t_nxt = n2_r;
            end
            6'(fsa_pkg::OP_PICK): t_nxt = pk_r;
            6'(fsa_pkg::OP_2DUP): begin
              wa_nxt[0] = a0;  wd_nxt[0] = t_r;
              wa_nxt[1] = ap1; wd_nxt[1] = n1_r; wn_nxt = 2'd2; c_nxt = c_r + 2'd2;
            end
            6'(fsa_pkg::OP_2DROP): begin
              t_nxt = n2_r; c_nxt = c_r - 2'd2;
            end
            6'(fsa_pkg::OP_2OVER): begin
              wa_nxt[0] = a0;  wd_nxt[0] = t_r;
              wa_nxt[1] = ap1; wd_nxt[1] = n3_r; wn_nxt = 2'd2;
              c_nxt = c_r + 2'd2; t_nxt = n2_r;
            end
            6'(fsa_pkg::OP_2SWAP): begin
              wa_nxt[0] = am3; wd_nxt[0] = n1_r;
              wa_nxt[1] = am2; wd_nxt[1] = t_r;
              wa_nxt[2] = am1; wd_nxt[2] = n3_r; wn_nxt = 2'd3; t_nxt = n2_r;
            end
            6'(fsa_pkg::OP_MUL): begin
              t_nxt = prod[31:0]; c_nxt = c_r - 1'b1;
            end
            6'(fsa_pkg::OP_TOR): begin
              rw_nxt = 1'b1; rwa_nxt = rc_r[RA_W-1:0]; rwd_nxt = t_r;
              rc_nxt = rc_r + 1'b1; t_nxt = n1_r; c_nxt = c_r - 1'b1;
            end
            6'(fsa_pkg::OP_FROMR): begin
              wa_nxt[0] = a0; wd_nxt[0] = t_r; wn_nxt = 2'd1;
              c_nxt = c_r + 1'b1; t_nxt = rv_r; rc_nxt = rc_r - 1'b1;
            end
            6'(fsa_pkg::OP_RFETCH): begin
              wa_nxt[0] = a0; wd_nxt[0] = t_r; wn_nxt = 2'd1;
              c_nxt = c_r + 1'b1; t_nxt = rv_r;
            end
            6'(fsa_pkg::OP_ABS), 6'(fsa_pkg::OP_NEG), 6'(fsa_pkg::OP_SHL),
            6'(fsa_pkg::OP_SHR), 6'(fsa_pkg::OP_INC), 6'(fsa_pkg::OP_DEC),
            6'(fsa_pkg::OP_ZEQ), 6'(fsa_pkg::OP_ZLT), 6'(fsa_pkg::OP_ZGT):
              t_nxt = alu_res;
            6'(fsa_pkg::OP_ADD), 6'(fsa_pkg::OP_SUB), 6'(fsa_pkg::OP_AND),
            6'(fsa_pkg::OP_OR), 6'(fsa_pkg::OP_XOR), 6'(fsa_pkg::OP_MAX),
            6'(fsa_pkg::OP_MIN), 6'(fsa_pkg::OP_EQ), 6'(fsa_pkg::OP_GT),
            6'(fsa_pkg::OP_LT), 6'(fsa_pkg::OP_NE), 6'(fsa_pkg::OP_GE),
            6'(fsa_pkg::OP_LE): begin
              t_nxt = alu_res; c_nxt = c_r - 1'b1;
            end
            default: ;
          endcase
        end
      end
      fsa_pkg::S_DIVW: begin
        if (div_done) begin
          unique case (kind_r)
            6'(fsa_pkg::OP_DIV): begin
              t_nxt = q_fix; c_nxt = c_r - 1'b1;
            end
            6'(fsa_pkg::OP_MOD): begin
              t_nxt = r_fix; c_nxt = c_r - 1'b1;
            end
            6'(fsa_pkg::OP_MULDIV): begin
              t_nxt = q_fix; c_nxt = c_r - 2'd2;
            end
            6'(fsa_pkg::OP_DIVMOD): begin
              wa_nxt[0] = am1; wd_nxt[0] = r_fix; wn_nxt = 2'd1; t_nxt = q_fix;
            end
            default: begin
              wa_nxt[0] = am2; wd_nxt[0] = r_fix; wn_nxt = 2'd1;
              t_nxt = q_fix; c_nxt = c_r - 1'b1;
            end
          endcase
        end
      end
      fsa_pkg::S_WR: begin
        rw_nxt = 1'b0;
        if (wi_r != wn_r) begin
          dwe    = 1'b1;
          wi_nxt = wi_r + 1'b1;
        end
      end
      fsa_pkg::S_RDS: dra = am1;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fsa_pkg::S_IDLE;
      t_r     <= fsa_pkg::TRUE32;
      c_r     <= '0;
      rc_r    <= '0;
      st_r    <= fsa_pkg::ST_OK;
      idx_r   <= '0;
      wn_r    <= '0;
      wi_r    <= '0;
      rw_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      t_r     <= t_nxt;
      c_r     <= c_nxt;
      rc_r    <= rc_nxt;
      st_r    <= st_nxt;
      idx_r   <= idx_nxt;
      wn_r    <= wn_nxt;
      wi_r    <= wi_nxt;
      rw_r    <= rw_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == fsa_pkg::S_IDLE && start) begin
      kind_r <= in_kind;
      lit_r  <= in_literal;
    end
    if (state_r == fsa_pkg::S_RD) begin
      case (idx_r)
        3'd1: begin
          n1_r <= drd_r;
          rv_r <= rrd_r;
        end
        3'd2: n2_r <= drd_r;
        3'd3: n3_r <= drd_r;
        3'd4: pk_r <= drd_r;
        default: ;
      endcase
    end
    if (state_r == fsa_pkg::S_MUL) prod_r <= prod;
    wa_r  <= wa_nxt;
    wd_r  <= wd_nxt;
    rwa_r <= rwa_nxt;
    rwd_r <= rwd_nxt;
  end

  // data stack memory
  always_ff @(posedge clk) begin
    if (dwe) dmem[dwa] <= dwd;
    drd_r <= dmem[dra];
  end

  // return stack memory
  always_ff @(posedge clk) begin
    if (state_r == fsa_pkg::S_WR && rw_r) rmem[rwa_r] <= rwd_r;
    rrd_r <= rmem[rc_r[RA_W-1:0] - 1'b1];
  end

  // result beat
  assign busy             = (state_r != fsa_pkg::S_IDLE);
  assign out_strobe       = (state_r == fsa_pkg::S_OUT);
  assign out_top_value    = t_r;
  assign out_second_value = (c_r != '0) ? drd_r : 32'd0;
  assign out_data_depth   = 7'(c_r);
  assign out_return_depth = 7'(rc_r);
  assign out_status       = st_r;

  // checks
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy) else $error("result beat while idle");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_strobe)) else $error("accept did not start work");
  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe && !busy) else $error("result beat repeated");
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (c_r <= CNT_W'(fsa_pkg::DATA_DEPTH)) && (rc_r <= CNT_W'(fsa_pkg::RETURN_DEPTH)))
    else $error("stack depth out of range");

endmodule

// ===== tb/sv/tb_forth_stack_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_forth_stack_alu
// Drives opcode beats into the stack alu and compares every result beat
// against a behavioral copy of the data and return stacks held here.
// ----------------------------------------------------------------------------
module tb_forth_stack_alu;
  import fsa_pkg::*;

  localparam int WATCHDOG = 20000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [5:0]  in_kind;
  logic signed [31:0] in_literal;
  logic        out_strobe;
  logic signed [31:0] out_top_value;
  logic signed [31:0] out_second_value;
  logic [6:0]  out_data_depth;
  logic [6:0]  out_return_depth;
  logic [2:0]  out_status;

  typedef struct {
    logic [31:0] top;
    logic [31:0] second;
    logic [6:0]  ddepth;
    logic [6:0]  rdepth;
    logic [2:0]  status;
  } stack_view_t;

  typedef struct {
    logic [5:0]  kind;
    logic [31:0] lit;
    logic        typed;
    logic [31:0] top;
    logic [2:0]  status;
  } row_t;

  // model state
  logic [31:0] m_top;
  logic [31:0] m_data [DATA_DEPTH];
  int unsigned m_dcnt;
  logic [31:0] m_ret [RETURN_DEPTH];
  int unsigned m_rcnt;

  stack_view_t view_q [$];
  // typed-in expectations from the directed table, checked only where typed is set
  logic        typed_q [$];
  logic [31:0] typed_top_q [$];
  logic [2:0]  typed_st_q [$];

  int errors;
  int mismatches;
  int beats_in;
  int beats_out;
  int idle_cnt;
  int fault_seen [8];
  bit timed_out;

  forth_stack_alu u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_literal(in_literal),
    .out_strobe(out_strobe), .out_top_value(out_top_value),
    .out_second_value(out_second_value), .out_data_depth(out_data_depth),
    .out_return_depth(out_return_depth), .out_status(out_status)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [31:0] abs32(logic [31:0] a);
    return a[31] ? 32'd0 - a : a;
  endfunction

  function automatic bit lt_s(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  // truncating signed divide of a 64-bit magnitude with sign nneg by d
  function automatic void trunc_div(logic [63:0] mn, bit nneg, logic [31:0] d,
                                    output logic [31:0] q, output logic [31:0] r);
    logic [63:0] md, qq, rr;
    md = {32'd0, abs32(d)};
    qq = mn / md;
    rr = mn % md;
    if (nneg != d[31]) qq = 64'd0 - qq;
    if (nneg) rr = 64'd0 - rr;
    q = qq[31:0];
    r = rr[31:0];
  endfunction

  function automatic int need_cnt(logic [5:0] k);
    case (k) inside
      OP_DROP, OP_OVER, OP_SWAP, OP_2DUP, OP_ADD, OP_MUL, OP_SUB, OP_DIV, OP_MOD,
      OP_DIVMOD, OP_AND, OP_OR, OP_XOR, OP_MAX, OP_MIN, OP_EQ, OP_GT, OP_LT,
      OP_NE, OP_GE, OP_LE, OP_TOR: return 1;
      OP_ROT, OP_2DROP, OP_MULDIV, OP_MULDIVMOD: return 2;
      OP_2OVER, OP_2SWAP: return 3;
      default: return 0;
    endcase
  endfunction

  function automatic int grow_cnt(logic [5:0] k);
    case (k) inside
      OP_LIT, OP_DUP, OP_OVER, OP_FROMR, OP_RFETCH: return 1;
      OP_2DUP, OP_2OVER: return 2;
      default: return 0;
    endcase
  endfunction

  // apply one opcode to the stack copy, return the visible view
  function automatic stack_view_t exec_op(logic [5:0] k, logic [31:0] lit);
    stack_view_t v;
    logic [2:0] st;
    logic [31:0] t, n, a, b, q, r;
    int unsigned c;
    st = ST_OK;
    c = m_dcnt;
    t = m_top;
    if (k <= OP_RFETCH) begin
      if ((k == OP_FROMR || k == OP_RFETCH) && m_rcnt == 0) st = ST_RET_UNDER;
      else if (c < need_cnt(k)) st = ST_DATA_UNDER;
      else if (k == OP_PICK && t >= c) st = ST_DATA_UNDER;
      else if (c + grow_cnt(k) > DATA_DEPTH) st = ST_DATA_OVER;
      else if (k == OP_TOR && m_rcnt >= RETURN_DEPTH) st = ST_RET_OVER;
      else if (k >= OP_DIV && k <= OP_MULDIVMOD && t == 0) st = ST_DIV_ZERO;
    end
    if (k <= OP_RFETCH && st == ST_OK) begin
      case (k) inside
        OP_LIT: begin m_data[c] = t; c++; t = lit; end
        OP_DUP: begin m_data[c] = t; c++; end
        OP_DROP: begin t = m_data[c-1]; c--; end
        OP_OVER: begin n = m_data[c-1]; m_data[c] = t; c++; t = n; end
        OP_SWAP: begin n = m_data[c-1]; m_data[c-1] = t; t = n; end
        OP_ROT: begin
          a = m_data[c-2]; m_data[c-2] = m_data[c-1]; m_data[c-1] = t; t = a;
        end
        OP_PICK: t = m_data[c-1-t];
        OP_2DUP: begin m_data[c] = t; m_data[c+1] = m_data[c-1]; c += 2; end
        OP_2DROP: begin t = m_data[c-2]; c -= 2; end
        OP_2OVER: begin
          a = m_data[c-3]; b = m_data[c-2];
          m_data[c] = t; m_data[c+1] = a; c += 2; t = b;
        end
        OP_2SWAP: begin
          a = m_data[c-3]; b = m_data[c-2];
          m_data[c-3] = m_data[c-1]; m_data[c-2] = t; m_data[c-1] = a; t = b;
        end
        OP_MULDIV, OP_MULDIVMOD: begin
          a = m_data[c-1]; b = m_data[c-2];
          trunc_div({32'd0, abs32(a)} * {32'd0, abs32(b)}, a[31] ^ b[31], t, q, r);
          if (k == OP_MULDIV) c -= 2;
          else begin c -= 1; m_data[c-1] = r; end
          t = q;
        end
        OP_DIVMOD: begin
          n = m_data[c-1];
          trunc_div({32'd0, abs32(n)}, n[31], t, q, r);
          m_data[c-1] = r; t = q;
        end
        OP_ABS: t = abs32(t);
        OP_NEG: t = 32'd0 - t;
        OP_SHL: t = t << 1;
        OP_SHR: t = {t[31], t[31:1]};
        OP_INC: t = t + 1;
        OP_DEC: t = t - 1;
        OP_ZEQ: t = (t == 0) ? TRUE32 : 32'd0;
        OP_ZLT: t = t[31] ? TRUE32 : 32'd0;
        OP_ZGT: t = lt_s(32'd0, t) ? TRUE32 : 32'd0;
        OP_TOR: begin m_ret[m_rcnt] = t; m_rcnt++; t = m_data[c-1]; c--; end
        OP_FROMR: begin m_data[c] = t; c++; t = m_ret[m_rcnt-1]; m_rcnt--; end
        OP_RFETCH: begin m_data[c] = t; c++; t = m_ret[m_rcnt-1]; end
        default: begin
          // binary ops: second op top
          n = m_data[c-1]; c--;
          case (k)
            OP_ADD: t = n + t;
            OP_MUL: t = n * t;
            OP_SUB: t = n - t;
            OP_DIV: begin trunc_div({32'd0, abs32(n)}, n[31], t, q, r); t = q; end
            OP_MOD: begin trunc_div({32'd0, abs32(n)}, n[31], t, q, r); t = r; end
            OP_AND: t = n & t;
            OP_OR:  t = n | t;
            OP_XOR: t = n ^ t;
            OP_MAX: t = lt_s(n, t) ? t : n;
            OP_MIN: t = lt_s(t, n) ? t : n;
            OP_EQ:  t = (n == t) ? TRUE32 : 32'd0;
            OP_GT:  t = lt_s(t, n) ? TRUE32 : 32'd0;
            OP_LT:  t = lt_s(n, t) ? TRUE32 : 32'd0;
            OP_NE:  t = (n != t) ? TRUE32 : 32'd0;
            OP_GE:  t = !lt_s(n, t) ? TRUE32 : 32'd0;
            default: t = !lt_s(t, n) ? TRUE32 : 32'd0;
          endcase
        end
      endcase
      m_top = t;
      m_dcnt = c;
    end
    v.top = m_top;
    v.second = (m_dcnt > 0) ? m_data[m_dcnt-1] : 32'd0;
    v.ddepth = m_dcnt[6:0];
    v.rdepth = m_rcnt[6:0];
    v.status = st;
    return v;
  endfunction

  // send one beat: drive at the falling edge, hold start until an accepting edge
  task automatic send_beat(logic [5:0] k, logic [31:0] lit, logic typed,
                           logic [31:0] ttop, logic [2:0] tst);
    view_q.push_back(exec_op(k, lit));
    typed_q.push_back(typed);
    typed_top_q.push_back(ttop);
    typed_st_q.push_back(tst);
    start = 1'b1;
    in_kind = k;
    in_literal = lit;
    do @(posedge clk); while (busy);
    beats_in++;
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic idle_gap(bit allow);
    if (allow && $urandom_range(99) < 21) repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    stack_view_t e;
    logic ty;
    logic [31:0] tt;
    logic [2:0] ts;
    bit bad;
    if (rst_n && out_strobe) begin
      beats_out <= beats_out + 1;
      if (view_q.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat top=%h", out_top_value);
      end else begin
        e = view_q.pop_front();
        ty = typed_q.pop_front();
        tt = typed_top_q.pop_front();
        ts = typed_st_q.pop_front();
        fault_seen[out_status]++;
        bad = (out_top_value !== e.top) || (out_second_value !== e.second) ||
              (out_data_depth !== e.ddepth) || (out_return_depth !== e.rdepth) ||
              (out_status !== e.status) ||
              (ty && ((out_top_value !== tt) || (out_status !== ts)));
        if (bad) begin
          errors++;
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp top=%h sec=%h dd=%0d rd=%0d st=%0d",
                     e.top, e.second, e.ddepth, e.rdepth, e.status);
            $display("          got top=%h sec=%h dd=%0d rd=%0d st=%0d",
                     out_top_value, out_second_value, out_data_depth,
                     out_return_depth, out_status);
          end
        end
      end
    end
  end

  // watchdog on cycles with no accepted beat and no result beat
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WATCHDOG) begin
      $display("watchdog expired");
      $display("simulation failed");
      $finish;
    end
  end

  // pick a random opcode, biased so the stacks move both ways
  function automatic logic [5:0] rand_kind();
    int sel;
    sel = $urandom_range(99);
    if (sel < 4) return 6'($urandom_range(42, 63));
    if (m_dcnt < 6 && sel < 40) return OP_LIT;
    if (m_dcnt > 56 && sel < 40) return OP_DROP;
    if (m_rcnt > 56 && sel < 50) return OP_FROMR;
    return 6'($urandom_range(0, 41));
  endfunction

  function automatic logic [31:0] rand_lit();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($urandom_range(0, 7));
      3: return 32'd0 - 32'($urandom_range(1, 4));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    row_t rows [$];
    logic [5:0] k;
    logic [31:0] lit;
    int quiet_lo;
    rst_n = 1'b0;
    start = 1'b0;
    in_kind = OP_LIT;
    in_literal = '0;
    errors = 0; mismatches = 0; beats_in = 0; beats_out = 0; idle_cnt = 0;
    m_top = TRUE32; m_dcnt = 0; m_rcnt = 0;
    foreach (m_data[i]) m_data[i] = '0;
    foreach (m_ret[i]) m_ret[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: underflows on empty stacks, extremes, division corners
    rows = '{
      '{OP_DROP,   32'd0, 1'b1, TRUE32, ST_DATA_UNDER},
      '{OP_FROMR,  32'd0, 1'b1, TRUE32, ST_RET_UNDER},
      '{OP_RFETCH, 32'd0, 1'b1, TRUE32, ST_RET_UNDER},
      '{OP_PICK,   32'd0, 1'b1, TRUE32, ST_DATA_UNDER},
      '{OP_LIT, 32'h8000_0000, 1'b1, 32'h8000_0000, ST_OK},
      '{OP_ABS,    32'd0, 1'b1, 32'h8000_0000, ST_OK},
      '{OP_NEG,    32'd0, 1'b1, 32'h8000_0000, ST_OK},
      '{OP_LIT,    TRUE32, 1'b1, TRUE32, ST_OK},
      '{OP_DIV,    32'd0, 1'b1, 32'h8000_0000, ST_OK},
      '{OP_LIT,    32'd0, 1'b1, 32'd0, ST_OK},
      '{OP_MOD,    32'd0, 1'b1, 32'd0, ST_DIV_ZERO},
      '{OP_PICK,   32'd0, 1'b0, 32'd0, ST_OK},
      '{OP_LIT, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, ST_OK},
      '{OP_SHR,    32'd0, 1'b0, 32'd0, ST_OK},
      '{OP_LIT,    32'd5, 1'b1, 32'd5, ST_OK},
      '{OP_LIT,    32'd3, 1'b1, 32'd3, ST_OK},
      '{OP_MULDIVMOD, 32'd0, 1'b0, 32'd0, ST_OK},
      '{OP_TOR,    32'd0, 1'b0, 32'd0, ST_OK},
      '{OP_RFETCH, 32'd0, 1'b0, 32'd0, ST_OK},
      '{OP_FROMR,  32'd0, 1'b0, 32'd0, ST_OK},
      '{OP_2SWAP,  32'd0, 1'b0, 32'd0, ST_OK},
      '{OP_DIVMOD, 32'd0, 1'b0, 32'd0, ST_OK},
      '{6'd63,     32'd0, 1'b1, 32'd0, ST_OK}
    };
    foreach (rows[i]) begin
      idle_gap(1'b1);
      send_beat(rows[i].kind, rows[i].lit, rows[i].typed, rows[i].top, rows[i].status);
    end

    // pause until every result is back
    while (view_q.size() != 0) @(negedge clk);

    // fill the data stack to overflow, move it onto the return stack, drain that past empty
    repeat (66) send_beat(OP_DUP, 32'd0, 1'b0, 32'd0, ST_OK);
    repeat (66) send_beat(OP_TOR, 32'd0, 1'b0, 32'd0, ST_OK);
    repeat (70) send_beat(OP_FROMR, 32'd0, 1'b0, 32'd0, ST_OK);

    // random part, with one quiet stretch of no gaps
    quiet_lo = $urandom_range(300, 900);
    for (int i = 0; i < 1400; i++) begin
      idle_gap(!(i >= quiet_lo && i < quiet_lo + 200));
      k = rand_kind();
      lit = rand_lit();
      send_beat(k, lit, 1'b0, 32'd0, ST_OK);
    end

    while (view_q.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);

    $display("%0d opcode beats sent, %0d result beats checked", beats_in, beats_out);
    $display("status counts ok=%0d dunder=%0d dover=%0d div0=%0d runder=%0d rover=%0d",
             fault_seen[0], fault_seen[1], fault_seen[2], fault_seen[3],
             fault_seen[4], fault_seen[5]);
    if (errors == 0 && view_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/fsa_pkg.sv
rtl/core/fsa_alu.sv
rtl/core/fsa_div.sv
rtl/core/forth_stack_alu.sv
tb/sv/tb_forth_stack_alu.sv
